// ===== hw/rtl/sscg_pkg.sv =====
// Shared types, sizes and codes for the shadow stack call graph checker.
// No dependencies; the interfaces and every other module but sscg_ram refer to it by scoped name.
`timescale 1ns / 1ps

package sscg_pkg;

  localparam int FUNC_COUNT  = 64;
  localparam int STACK_DEPTH = 16;
  localparam int Q_DEPTH     = 2;

  localparam int ACT_W    = 2;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 4;
  localparam int DEPTH_W  = 5;

  localparam int FID_W = $clog2(FUNC_COUNT);
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int QP_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_ENTER  = 2'd0,
    ACT_EXIT   = 2'd1,
    ACT_LOAD   = 2'd2,
    ACT_VERIFY = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED         = 4'd0,
    ST_DUPLICATE      = 4'd1,
    ST_POPPED         = 4'd2,
    ST_NOT_TOP        = 4'd3,
    ST_UNDERFLOW      = 4'd4,
    ST_OVERFLOW       = 4'd5,
    ST_EDGE_LOADED    = 4'd6,
    ST_PAIR_ALLOWED   = 4'd7,
    ST_PAIR_FORBIDDEN = 4'd8,
    ST_UNKNOWN        = 4'd9,
    ST_NOTHING        = 4'd10
  } status_t;

  // Classified command as handed from the front end to the back end
  typedef struct packed {
    action_t         act;
    logic [ID_W-1:0] fid;
    logic [ID_W-1:0] cid;
    logic            fid_bad;
    logic            cid_bad;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_st_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] depth;
  } bk_st_t;

  function automatic logic id_bad(input logic [ID_W-1:0] id);
    return 32'(id) >= FUNC_COUNT;
  endfunction

  function automatic logic [FID_W-1:0] to_fidx(input logic [ID_W-1:0] id);
    return FID_W'(id);
  endfunction

endpackage

// ===== hw/rtl/sscg_req_if.sv =====
// Request channel: valid/ready handshake carrying one command item.
// Depends on sscg_pkg for field widths.
`timescale 1ns / 1ps

interface sscg_req_if;
  logic                      valid;
  logic                      ready;
  logic [sscg_pkg::ACT_W-1:0] action;
  logic [sscg_pkg::ID_W-1:0]  function_id;
  logic [sscg_pkg::ID_W-1:0]  caller_id;

  modport source (output valid, action, function_id, caller_id, input ready);
  modport sink   (input valid, action, function_id, caller_id, output ready);
endinterface

// ===== hw/rtl/sscg_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result item.
// Depends on sscg_pkg for field widths.
`timescale 1ns / 1ps

interface sscg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sscg_pkg::STATUS_W-1:0] status;
  logic [sscg_pkg::ID_W-1:0]     pair_caller;
  logic [sscg_pkg::ID_W-1:0]     pair_callee;
  logic [sscg_pkg::DEPTH_W-1:0]  stack_depth;
  logic                          last;

  modport source (output valid, status, pair_caller, pair_callee, stack_depth, last,
                  input ready);
  modport sink   (input valid, status, pair_caller, pair_callee, stack_depth, last,
                  output ready);
endinterface

// ===== hw/rtl/sscg_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; read data holds while read enable is low.
`timescale 1ns / 1ps

module sscg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/sscg_front.sv =====
// Front end: takes request transfers and classifies them (action, ID range).
// Depends on sscg_pkg and sscg_req_if; feeds sscg_queue.
`timescale 1ns / 1ps

module sscg_front (
  sscg_req_if.sink       req,
  input  sscg_pkg::q_st_t q_st,
  output logic           push,
  output sscg_pkg::cmd_t cmd
);

  assign req.ready = !q_st.full;
  assign push      = req.valid && !q_st.full;

  always_comb begin
    cmd.act     = sscg_pkg::action_t'(req.action);
    cmd.fid     = req.function_id;
    cmd.cid     = req.caller_id;
    cmd.fid_bad = sscg_pkg::id_bad(req.function_id);
    cmd.cid_bad = sscg_pkg::id_bad(req.caller_id);
  end

endmodule

// ===== hw/rtl/sscg_queue.sv =====
// Short command queue decoupling the front end from the back end.
// Depends on sscg_pkg.
`timescale 1ns / 1ps

module sscg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sscg_pkg::cmd_t        cmd_in,
  input  logic                  pop,
  output sscg_pkg::cmd_t        cmd_out,
  output sscg_pkg::q_st_t       q_st
);

  sscg_pkg::cmd_t                entry [sscg_pkg::Q_DEPTH];
  logic [sscg_pkg::QP_W-1:0]     wptr;
  logic [sscg_pkg::QP_W-1:0]     rptr;
  logic [sscg_pkg::QC_W-1:0]     fill;

  localparam logic [sscg_pkg::QP_W-1:0] PTR_LAST = sscg_pkg::QP_W'(sscg_pkg::Q_DEPTH - 1);

  assign cmd_out    = entry[rptr];
  assign q_st.valid = fill != '0;
  assign q_st.full  = fill == sscg_pkg::QC_W'(sscg_pkg::Q_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= cmd_in;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + sscg_pkg::QP_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + sscg_pkg::QP_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + sscg_pkg::QC_W'(1);
      end else if (pop && !push) begin
        fill <= fill - sscg_pkg::QC_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/sscg_back.sv =====
// Back end: shadow stack, on-stack and known maps, edge table, result register.
// Depends on sscg_pkg, sscg_rsp_if and sscg_ram (stack and edge memories).
`timescale 1ns / 1ps

module sscg_back (
  input  logic             clk,
  input  logic             rst,
  input  sscg_pkg::cmd_t   q_cmd,
  input  sscg_pkg::q_st_t  q_st,
  output logic             pop,
  sscg_rsp_if.source       rsp,
  output sscg_pkg::bk_st_t bk_st
);

  localparam int FC = sscg_pkg::FUNC_COUNT;
  localparam int IW = sscg_pkg::ID_W;
  localparam int SW = sscg_pkg::SP_W;
  localparam int CW = sscg_pkg::CNT_W;
  localparam int FW = sscg_pkg::FID_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXIT_CMP,
    S_LOAD_WR,
    S_V_CALLEE,
    S_V_CALLER,
    S_V_EDGE
  } state_t;

  state_t               state;
  sscg_pkg::cmd_t       cur;
  logic [CW-1:0]        count;
  logic [FC-1:0]        on_map;
  logic [FC-1:0]        known_map;
  logic [FC-1:0]        edge_vld;
  logic [SW-1:0]        idx;
  logic [IW-1:0]        callee;
  logic [IW-1:0]        caller;

  logic                 res_valid;
  sscg_pkg::status_t    res_status;
  logic [IW-1:0]        res_caller;
  logic [IW-1:0]        res_callee;
  logic [CW-1:0]        res_depth;
  logic                 res_last;

  // memory ports
  logic                 stk_we, stk_re;
  logic [SW-1:0]        stk_waddr, stk_raddr;
  logic [IW-1:0]        stk_wdata, stk_rdata;
  logic                 edg_we, edg_re;
  logic [FW-1:0]        edg_waddr, edg_raddr;
  logic [FC-1:0]        edg_wdata, edg_rdata;

  // result staging
  logic                 emit;
  sscg_pkg::status_t    emit_status;
  logic [IW-1:0]        emit_caller;
  logic [IW-1:0]        emit_callee;
  logic [CW-1:0]        emit_depth;
  logic                 emit_last;

  logic                 slot_free;
  logic                 go;
  logic [CW-1:0]        cnt_m1;
  logic                 stk_full;
  logic                 push_ok;
  logic                 load_ok;
  logic                 top_match;
  logic                 pair_bad;
  logic                 pair_ok;

  sscg_ram #(.WIDTH(IW), .DEPTH(sscg_pkg::STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  sscg_ram #(.WIDTH(FC), .DEPTH(FC)) u_edge_ram (
    .clk   (clk),
    .we    (edg_we),
    .waddr (edg_waddr),
    .wdata (edg_wdata),
    .re    (edg_re),
    .raddr (edg_raddr),
    .rdata (edg_rdata)
  );

  assign slot_free = !res_valid || rsp.ready;
  assign go        = (state == S_IDLE) && q_st.valid && slot_free;
  assign cnt_m1    = count - CW'(1);
  assign stk_full  = count >= CW'(sscg_pkg::STACK_DEPTH);
  assign push_ok   = !q_cmd.fid_bad && !on_map[sscg_pkg::to_fidx(q_cmd.fid)] && !stk_full;
  assign load_ok   = !q_cmd.fid_bad && !q_cmd.cid_bad;
  assign top_match = stk_rdata == cur.fid;

  assign pair_bad = sscg_pkg::id_bad(caller) || sscg_pkg::id_bad(callee) ||
                    !known_map[sscg_pkg::to_fidx(caller)] ||
                    !known_map[sscg_pkg::to_fidx(callee)];
  // a row that was never written is masked by its edge_vld bit
  assign pair_ok  = edge_vld[sscg_pkg::to_fidx(caller)] &&
                    edg_rdata[sscg_pkg::to_fidx(callee)];

  assign pop = go;

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.pair_caller = res_caller;
  assign rsp.pair_callee = res_callee;
  assign rsp.stack_depth = sscg_pkg::DEPTH_W'(res_depth);
  assign rsp.last        = res_last;

  assign bk_st.busy  = state != S_IDLE;
  assign bk_st.depth = count;

  always_comb begin
    stk_we      = 1'b0;
    stk_waddr   = SW'(count);
    stk_wdata   = q_cmd.fid;
    stk_re      = 1'b0;
    stk_raddr   = cnt_m1[SW-1:0];
    edg_we      = 1'b0;
    edg_waddr   = sscg_pkg::to_fidx(cur.cid);
    edg_wdata   = (edge_vld[sscg_pkg::to_fidx(cur.cid)] ? edg_rdata : '0) |
                  (FC'(1) << sscg_pkg::to_fidx(cur.fid));
    edg_re      = 1'b0;
    edg_raddr   = sscg_pkg::to_fidx(q_cmd.cid);
    emit        = 1'b0;
    emit_status = sscg_pkg::ST_UNKNOWN;
    emit_caller = '0;
    emit_callee = '0;
    emit_depth  = count;
    emit_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (go) begin
          unique case (q_cmd.act)
            sscg_pkg::ACT_ENTER: begin
              emit = 1'b1;
              if (q_cmd.fid_bad) begin
                emit_status = sscg_pkg::ST_UNKNOWN;
              end else if (on_map[sscg_pkg::to_fidx(q_cmd.fid)]) begin
                emit_status = sscg_pkg::ST_DUPLICATE;
              end else if (stk_full) begin
                emit_status = sscg_pkg::ST_OVERFLOW;
              end else begin
                emit_status = sscg_pkg::ST_PUSHED;
                emit_depth  = count + CW'(1);
                stk_we      = 1'b1;
              end
            end
            sscg_pkg::ACT_EXIT: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = sscg_pkg::ST_UNDERFLOW;
              end else begin
                stk_re = 1'b1;
              end
            end
            sscg_pkg::ACT_LOAD: begin
              if (load_ok) begin
                edg_re = 1'b1;
              end else begin
                emit        = 1'b1;
                emit_status = sscg_pkg::ST_UNKNOWN;
              end
            end
            sscg_pkg::ACT_VERIFY: begin
              if (count < CW'(2)) begin
                emit        = 1'b1;
                emit_status = sscg_pkg::ST_NOTHING;
              end else begin
                stk_re = 1'b1;
              end
            end
          endcase
        end
      end
      S_EXIT_CMP: begin
        emit        = 1'b1;
        emit_status = top_match ? sscg_pkg::ST_POPPED : sscg_pkg::ST_NOT_TOP;
        emit_depth  = top_match ? cnt_m1 : count;
      end
      S_LOAD_WR: begin
        edg_we      = 1'b1;
        emit        = 1'b1;
        emit_status = sscg_pkg::ST_EDGE_LOADED;
      end
      S_V_CALLEE: begin
        stk_re    = 1'b1;
        stk_raddr = idx - SW'(1);
      end
      S_V_CALLER: begin
        edg_re    = 1'b1;
        edg_raddr = sscg_pkg::to_fidx(stk_rdata);
      end
      S_V_EDGE: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_caller = caller;
          emit_callee = callee;
          emit_last   = idx == SW'(1);
          if (pair_bad) begin
            emit_status = sscg_pkg::ST_UNKNOWN;
          end else if (pair_ok) begin
            emit_status = sscg_pkg::ST_PAIR_ALLOWED;
          end else begin
            emit_status = sscg_pkg::ST_PAIR_FORBIDDEN;
          end
          // fetch the caller of the next pair down
          if (idx != SW'(1)) begin
            stk_re    = 1'b1;
            stk_raddr = idx - SW'(2);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_status <= emit_status;
      res_caller <= emit_caller;
      res_callee <= emit_callee;
      res_depth  <= emit_depth;
      res_last   <= emit_last;
    end
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      on_map    <= '0;
      known_map <= '0;
      edge_vld  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (go) begin
            cur <= q_cmd;
            unique case (q_cmd.act)
              sscg_pkg::ACT_ENTER: begin
                if (push_ok) begin
                  count <= count + CW'(1);
                  on_map[sscg_pkg::to_fidx(q_cmd.fid)] <= 1'b1;
                end
              end
              sscg_pkg::ACT_EXIT: begin
                if (count != '0) begin
                  state <= S_EXIT_CMP;
                end
              end
              sscg_pkg::ACT_LOAD: begin
                if (load_ok) begin
                  state <= S_LOAD_WR;
                end
              end
              sscg_pkg::ACT_VERIFY: begin
                if (count >= CW'(2)) begin
                  idx   <= cnt_m1[SW-1:0];
                  state <= S_V_CALLEE;
                end
              end
            endcase
          end
        end
        S_EXIT_CMP: begin
          if (top_match) begin
            count <= cnt_m1;
            if (!cur.fid_bad) begin
              on_map[sscg_pkg::to_fidx(cur.fid)] <= 1'b0;
            end
          end
          state <= S_IDLE;
        end
        S_LOAD_WR: begin
          edge_vld[sscg_pkg::to_fidx(cur.cid)] <= 1'b1;
          known_map <= known_map | (FC'(1) << sscg_pkg::to_fidx(cur.cid)) |
                       (FC'(1) << sscg_pkg::to_fidx(cur.fid));
          state <= S_IDLE;
        end
        S_V_CALLEE: begin
          callee <= stk_rdata;
          state  <= S_V_CALLER;
        end
        S_V_CALLER: begin
          caller <= stk_rdata;
          state  <= S_V_EDGE;
        end
        S_V_EDGE: begin
          if (slot_free) begin
            if (idx == SW'(1)) begin
              state <= S_IDLE;
            end else begin
              idx    <= idx - SW'(1);
              callee <= caller;
              state  <= S_V_CALLER;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/shadow_stack_call_graph_checker_core.sv =====
// Top level of the shadow stack call graph checker: front end, queue, back end.
// Depends on sscg_pkg, sscg_req_if, sscg_rsp_if, sscg_front, sscg_queue, sscg_back.
`timescale 1ns / 1ps
//
//  channel  dir  payload                                             transfer
//  req      in   action, function_id, caller_id                      valid && ready
//  rsp      out  status, pair_caller, pair_callee, stack_depth, last valid && ready
//
//  Back end: enter, and any item rejected at decode, finish in S_IDLE; exit and
//  edge load need a registered read of the stack or edge memory; verify reads the
//  top entry, then one stack read and one edge row read per pair.
//  Reset clears the count and all maps; the edge table uses per-row valid bits,
//  so no clearing pass is needed. The queue accepts while the back end works;
//  the back end holds a pending result until rsp is ready.

module shadow_stack_call_graph_checker_core (
  input  logic       clk,
  input  logic       rst,
  sscg_req_if.sink   req,
  sscg_rsp_if.source rsp
);

  sscg_pkg::cmd_t   f_cmd;
  sscg_pkg::cmd_t   q_cmd;
  sscg_pkg::q_st_t  q_st;
  sscg_pkg::bk_st_t bk_st;
  logic             push;
  logic             pop;

  sscg_front u_front (
    .req  (req),
    .q_st (q_st),
    .push (push),
    .cmd  (f_cmd)
  );

  sscg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (f_cmd),
    .pop     (pop),
    .cmd_out (q_cmd),
    .q_st    (q_st)
  );

  sscg_back u_back (
    .clk   (clk),
    .rst   (rst),
    .q_cmd (q_cmd),
    .q_st  (q_st),
    .pop   (pop),
    .rsp   (rsp),
    .bk_st (bk_st)
  );

  // a non-final verify result means the walk is still going
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> bk_st.busy)
    else $error("back end idle with verify results outstanding");

  a_pair_depth: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == sscg_pkg::ST_PAIR_ALLOWED ||
                   rsp.status == sscg_pkg::ST_PAIR_FORBIDDEN))
    |-> (rsp.stack_depth >= sscg_pkg::DEPTH_W'(2)))
    else $error("pair result with fewer than two stack entries");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    bk_st.depth <= sscg_pkg::CNT_W'(sscg_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_st.valid)
    else $error("queue popped while empty");

endmodule
